### rtl/fspa_pkg.sv
package fspa_pkg;

  typedef enum logic [1:0] {
    FUNC_GET   = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_RESET = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

endpackage

### rtl/fspa_ram.sv
module fspa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/fixed_slot_pool_allocator_core.sv
// out_valid follows start in the next cycle; the grant is read from the free-list RAM.
// Throughput: one beat per clock, every clock; busy stays low.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst_n low, synchronous): all slots free, list 0..SLOTS-1 in order, active_slots
// = SLOTS, in-use count zero. A cfg write does so with active_slots = cfg_wdata clamped.
module fixed_slot_pool_allocator_core
  import fspa_pkg::*;
#(
  parameter int SLOTS = 64,
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    in_func,
  input  logic [SW-1:0] in_slot,
  output logic          out_valid,
  output logic [SW-1:0] out_granted_slot,
  output logic [1:0]    out_status,
  output logic [CW-1:0] out_in_use_count,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata
);

  logic [CW-1:0]    active_r, active_nxt;
  logic [CW-1:0]    free_cnt_r, free_cnt_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic [SW-1:0]    rp_r, rp_nxt;
  logic [SW-1:0]    wp_r, wp_nxt;
  logic [SLOTS-1:0] vld_r, vld_nxt;
  logic [SLOTS-1:0] inuse_r, inuse_nxt;
  logic             out_valid_r;
  logic             get_ok_r, get_ok_nxt;
  logic             vld_rd_r;
  logic [SW-1:0]    rd_idx_r;
  status_t          status_r, status_nxt;

  logic             ram_we;
  logic [SW-1:0]    ram_rdata;
  logic [SW-1:0]    grant_val;
  logic [SLOTS-1:0] inuse_eff;
  logic             slot_inuse;
  logic             range_bad;
  logic [CW-1:0]    cfg_clamped;
  func_t            func;

  fspa_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS)
  ) u_free_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_slot),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  function automatic logic [SW-1:0] ptr_inc(input logic [SW-1:0] p);
    ptr_inc = (p == SW'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SW-1:0] wp_start(input logic [CW-1:0] a);
    wp_start = (a == CW'(SLOTS)) ? '0 : a[SW-1:0];
  endfunction

  assign func      = func_t'(in_func);
  assign grant_val = vld_rd_r ? ram_rdata : rd_idx_r;
  assign range_bad = CW'(in_slot) >= active_r;

  always_comb begin
    cfg_clamped = cfg_wdata;
    if (cfg_wdata == '0) begin
      cfg_clamped = CW'(1);
    end else if (cfg_wdata > CW'(SLOTS)) begin
      cfg_clamped = CW'(SLOTS);
    end
  end

  // commit the slot granted by the previous beat
  always_comb begin
    inuse_eff = inuse_r;
    if (get_ok_r) begin
      inuse_eff[grant_val] = 1'b1;
    end
  end

  assign slot_inuse = inuse_eff[in_slot];

  always_comb begin
    active_nxt   = active_r;
    free_cnt_nxt = free_cnt_r;
    used_nxt     = used_r;
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    vld_nxt      = vld_r;
    inuse_nxt    = inuse_eff;
    get_ok_nxt   = 1'b0;
    status_nxt   = ST_OK;
    ram_we       = 1'b0;
    if (cfg_we) begin
      active_nxt   = cfg_clamped;
      free_cnt_nxt = cfg_clamped;
      used_nxt     = '0;
      rp_nxt       = '0;
      wp_nxt       = wp_start(cfg_clamped);
      vld_nxt      = '0;
      inuse_nxt    = '0;
    end else if (start) begin
      case (func)
        FUNC_GET: begin
          if (free_cnt_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            get_ok_nxt   = 1'b1;
            rp_nxt       = ptr_inc(rp_r);
            free_cnt_nxt = free_cnt_r - 1'b1;
            used_nxt     = used_r + 1'b1;
          end
        end
        FUNC_FREE: begin
          if (range_bad) begin
            status_nxt = ST_RANGE;
          end else if (!slot_inuse) begin
            status_nxt = ST_DOUBLE;
          end else begin
            ram_we             = 1'b1;
            vld_nxt[wp_r]      = 1'b1;
            wp_nxt             = ptr_inc(wp_r);
            free_cnt_nxt       = free_cnt_r + 1'b1;
            inuse_nxt[in_slot] = 1'b0;
            if (used_r != '0) begin
              used_nxt = used_r - 1'b1;
            end
          end
        end
        FUNC_RESET: begin
          free_cnt_nxt = active_r;
          used_nxt     = '0;
          rp_nxt       = '0;
          wp_nxt       = wp_start(active_r);
          vld_nxt      = '0;
          inuse_nxt    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= CW'(SLOTS);
      free_cnt_r  <= CW'(SLOTS);
      used_r      <= '0;
      rp_r        <= '0;
      wp_r        <= '0;
      vld_r       <= '0;
      inuse_r     <= '0;
      out_valid_r <= 1'b0;
      get_ok_r    <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      free_cnt_r  <= free_cnt_nxt;
      used_r      <= used_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      vld_r       <= vld_nxt;
      inuse_r     <= inuse_nxt;
      out_valid_r <= start;
      get_ok_r    <= get_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rd_idx_r <= rp_r;
    vld_rd_r <= vld_r[rp_r];
  end

  assign busy             = 1'b0;
  assign out_valid        = out_valid_r;
  assign out_granted_slot = get_ok_r ? grant_val : '0;
  assign out_status       = status_r;
  assign out_in_use_count = used_r;

endmodule

### rtl/fspa_chk.sv
module fspa_chk
  import fspa_pkg::*;
#(
  parameter int SLOTS = 64,
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic [1:0]    in_func,
  input logic [SW-1:0] in_slot,
  input logic          out_valid,
  input logic [SW-1:0] out_granted_slot,
  input logic [1:0]    out_status,
  input logic [CW-1:0] out_in_use_count,
  input logic          cfg_we,
  input logic [CW-1:0] cfg_wdata
);

  a_beat_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without accepted beat");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_granted_slot == '0)
    else $error("nonzero slot on failed beat");

  a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY && !$past(cfg_we))
      |-> out_in_use_count == $past(out_in_use_count))
    else $error("in-use count moved on empty pool");

  a_get_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK && $past(in_func) == FUNC_GET && !$past(cfg_we))
      |-> out_in_use_count == $past(out_in_use_count) + 1'b1)
    else $error("in-use count not advanced by grant");

  logic unused_ok;
  assign unused_ok = ^{in_slot, cfg_wdata};

endmodule

bind fixed_slot_pool_allocator_core fspa_chk #(
  .SLOTS (SLOTS)
) u_fspa_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_func          (in_func),
  .in_slot          (in_slot),
  .out_valid        (out_valid),
  .out_granted_slot (out_granted_slot),
  .out_status       (out_status),
  .out_in_use_count (out_in_use_count),
  .cfg_we           (cfg_we),
  .cfg_wdata        (cfg_wdata)
);
